/* hdl/port_usage_counter_top_n_assert.svh */
// ----------------------------------------------------------------------------
// Port usage counter assertion macros
// Wrappers for concurrent assertions; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PORT_USAGE_COUNTER_TOP_N_ASSERT_SVH
`define PORT_USAGE_COUNTER_TOP_N_ASSERT_SVH
`ifndef SYNTHESIS
`define PUC_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define PUC_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define PUC_ASSERT_IMP(label, clk, rst_n, a, c)
`define PUC_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* hdl/puc_pkg.sv */
// ----------------------------------------------------------------------------
// puc_pkg
// Shared constants and types of the port usage counter.
// ----------------------------------------------------------------------------
package puc_pkg;
  localparam int PortCount = 65536;
  localparam int TopCount  = 10;
  localparam int PortW     = $clog2(PortCount);
  localparam int TopW      = $clog2(TopCount + 1);
  localparam int QDepth    = 4;
  localparam int QW        = $clog2(QDepth);

  localparam logic       CMD_PACKET = 1'b0;
  localparam logic       CMD_EXPORT = 1'b1;
  localparam logic [1:0] ROW_TOP    = 2'd0;
  localparam logic [1:0] ROW_ALL    = 2'd1;
  localparam logic [1:0] ROW_NONIP  = 2'd2;
  localparam logic [1:0] ROW_REST   = 2'd3;

  // classified work item passed from front to back
  typedef struct packed {
    logic        is_export;
    logic        to_port;   // counts into a port entry
    logic        to_nonip;
    logic [15:0] len;
    logic [15:0] port;
  } work_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] port;
    logic [63:0] pkts;
    logic [63:0] bytes;
    logic        last;
  } row_t;
endpackage

/* hdl/port_usage_counter_top_n.sv */
// ----------------------------------------------------------------------------
// port_usage_counter_top_n
// Per-destination-port traffic histogram with a top-N export report.
// ----------------------------------------------------------------------------
// A front end takes input beats into a four-entry queue; a back end owns two
// 64K x 64 counter memories. After reset the back end clears both memories,
// one entry a cycle, before it takes work. A packet beat counted into a port
// goes through a read-modify-write (S_RMW_RD, then S_RMW_WR); other packet
// beats are done in S_IDLE alone. An export is accepted, then scans every
// port through S_SCAN_RD, S_SCAN_WAIT and S_SCAN_OFFER in turn (one memory
// read per port), then emits the top rows and leaves the top-row loop,
// stretched by output stalls. The back end takes no new work until the Rest
// row has been taken. Results come one row per beat.
module port_usage_counter_top_n (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_frame_length,
  input  logic        in_transport_is_tcp_udp,
  input  logic [15:0] in_dest_port,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_row_kind,
  output logic [15:0] out_port_number,
  output logic [63:0] out_packet_total,
  output logic [63:0] out_byte_total,
  output logic        out_last_row
);
  import puc_pkg::*;
`include "port_usage_counter_top_n_assert.svh"

  logic  q_valid, q_ready, busy;
  work_t q_data;
  row_t  row;

  puc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_frame_length,
    .in_transport_is_tcp_udp, .in_dest_port,
    .q_valid, .q_ready, .q_data
  );

  puc_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .row_valid(out_valid), .row_ready(out_ready), .row, .busy
  );

  assign out_row_kind     = row.kind;
  assign out_port_number  = row.port;
  assign out_packet_total = row.pkts;
  assign out_byte_total   = row.bytes;
  assign out_last_row     = row.last;

  // summary rows never name a port; last beat is always a Rest row
  `PUC_ASSERT_IMP(a_sum_port, clk, rst_n, out_valid && out_row_kind != ROW_TOP, ~|out_port_number)
  `PUC_ASSERT_IMP(a_last_rest, clk, rst_n, out_valid && out_last_row, out_row_kind == ROW_REST)
  // back end takes no work while a row is pending
  `PUC_ASSERT_IMP(a_busy, clk, rst_n, out_valid, busy && !q_ready)
endmodule

/* hdl/puc_front.sv */
// ----------------------------------------------------------------------------
// puc_front
// Accepts input beats, classifies them and queues work for the back end.
// ----------------------------------------------------------------------------
module puc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [15:0]         in_frame_length,
  input  logic                in_transport_is_tcp_udp,
  input  logic [15:0]         in_dest_port,
  output logic                q_valid,
  input  logic                q_ready,
  output puc_pkg::work_t      q_data
);
  import puc_pkg::*;

  work_t           mem_r [QDepth];
  logic [QW:0]     wp_r, rp_r;
  logic [QW:0]     wp_nxt, rp_nxt;
  work_t           w;
  logic            in_port_range;

  assign in_port_range = (32'(in_dest_port) < PortCount);
  always_comb begin
    w.is_export = (in_cmd == CMD_EXPORT);
    w.to_port   = (in_cmd == CMD_PACKET) && in_transport_is_tcp_udp && in_port_range;
    w.to_nonip  = (in_cmd == CMD_PACKET) && !in_transport_is_tcp_udp;
    w.len       = in_frame_length;
    w.port      = in_dest_port;
  end

  assign in_ready = (wp_r - rp_r) != (QW+1)'(QDepth);
  assign q_valid  = wp_r != rp_r;
  assign q_data   = mem_r[rp_r[QW-1:0]];
  assign wp_nxt   = wp_r + (QW+1)'(in_valid && in_ready);
  assign rp_nxt   = rp_r + (QW+1)'(q_valid && q_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
    if (in_valid && in_ready) mem_r[wp_r[QW-1:0]] <= w;
  end
endmodule

/* hdl/puc_back.sv */
// ----------------------------------------------------------------------------
// puc_back
// Counter memories, clearing pass, read-modify-write, scan and report rows.
// ----------------------------------------------------------------------------
module puc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  output logic           q_ready,
  input  puc_pkg::work_t q_data,
  output logic           row_valid,
  input  logic           row_ready,
  output puc_pkg::row_t  row,
  output logic           busy
);
  import puc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RMW_RD, S_RMW_WR, S_SCAN_RD, S_SCAN_WAIT, S_SCAN_OFFER,
    S_EMIT, S_ALL, S_NONIP, S_REST
  } state_t;

  logic [63:0] pk_mem [PortCount];
  logic [63:0] by_mem [PortCount];
  logic [63:0] pk_rd_r, by_rd_r;
  logic [PortW-1:0] addr_r;
  logic             mem_we;
  logic [63:0]      pk_wd, by_wd;

  state_t          st_r;
  logic [PortW:0]  cnt_r;         // sweep index, one bit wider than a port number
  logic [PortW-1:0] scan_port_r;
  work_t           cur_r;
  logic [63:0]     all_p_r, all_b_r, non_p_r, non_b_r, rest_p_r, rest_b_r;
  logic [15:0]     t_port_r [TopCount];
  logic [63:0]     t_pk_r   [TopCount];
  logic [63:0]     t_by_r   [TopCount];
  logic [TopW-1:0] n_r, ei_r;
  row_t            row_r;
  logic            row_v_r;
  logic            row_load;      // a new row goes into the output register

  // insertion: entries with bytes >= new stay ahead
  logic [TopCount-1:0] keep;
  always_comb
    for (int i = 0; i < TopCount; i++)
      keep[i] = (TopW'(i) < n_r) && (t_by_r[i] >= by_rd_r);

  always_comb begin
    mem_we = 1'b0;
    pk_wd  = '0;
    by_wd  = '0;
    if (st_r == S_CLEAR) mem_we = 1'b1;
    else if (st_r == S_RMW_WR) begin
      mem_we = 1'b1;
      pk_wd  = pk_rd_r + 64'd1;
      by_wd  = by_rd_r + 64'(cur_r.len);
    end
  end

  assign row_load = (!row_v_r || row_ready) &&
                    ((st_r == S_EMIT && ei_r != n_r) || st_r == S_ALL ||
                     st_r == S_NONIP || st_r == S_REST);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pk_mem[addr_r] <= pk_wd;
      by_mem[addr_r] <= by_wd;
    end
    pk_rd_r <= pk_mem[addr_r];
    by_rd_r <= by_mem[addr_r];
  end

  assign q_ready   = (st_r == S_IDLE) && !row_v_r;
  assign row_valid = row_v_r;
  assign row       = row_r;
  assign busy      = (st_r != S_IDLE) || row_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLEAR;
      cnt_r   <= '0;
      addr_r  <= '0;
      row_v_r <= 1'b0;
      all_p_r <= '0;
      all_b_r <= '0;
      non_p_r <= '0;
      non_b_r <= '0;
      n_r     <= '0;
      ei_r    <= '0;
    end else begin
      row_v_r <= row_load || (row_v_r && !row_ready);
      unique case (st_r)
        S_CLEAR: begin
          addr_r <= addr_r + PortW'(1);
          if (addr_r == PortW'(PortCount - 1)) st_r <= S_IDLE;
        end
        S_IDLE: if (q_valid && q_ready) begin
          cur_r <= q_data;
          if (q_data.is_export) begin
            n_r    <= '0;
            cnt_r  <= '0;
            addr_r <= '0;
            st_r   <= S_SCAN_RD;
          end else begin
            all_p_r <= all_p_r + 64'd1;
            all_b_r <= all_b_r + 64'(q_data.len);
            if (q_data.to_nonip) begin
              non_p_r <= non_p_r + 64'd1;
              non_b_r <= non_b_r + 64'(q_data.len);
            end
            if (q_data.to_port) begin
              addr_r <= q_data.port[PortW-1:0];
              st_r   <= S_RMW_RD;
            end
          end
        end
        S_RMW_RD: st_r <= S_RMW_WR;   // read data registered this edge
        S_RMW_WR: st_r <= S_IDLE;
        S_SCAN_RD: begin
          scan_port_r <= addr_r;
          st_r        <= S_SCAN_WAIT;
        end
        S_SCAN_WAIT: st_r <= S_SCAN_OFFER;
        S_SCAN_OFFER: begin
          if (pk_rd_r != 64'd0 && !keep[TopCount-1]) begin
            for (int i = TopCount - 1; i > 0; i--) begin
              if (!keep[i]) begin
                if (keep[i-1]) begin
                  t_port_r[i] <= 16'(scan_port_r);
                  t_pk_r[i]   <= pk_rd_r;
                  t_by_r[i]   <= by_rd_r;
                end else begin
                  t_port_r[i] <= t_port_r[i-1];
                  t_pk_r[i]   <= t_pk_r[i-1];
                  t_by_r[i]   <= t_by_r[i-1];
                end
              end
            end
            if (!keep[0]) begin
              t_port_r[0] <= 16'(scan_port_r);
              t_pk_r[0]   <= pk_rd_r;
              t_by_r[0]   <= by_rd_r;
            end
            if (n_r != TopW'(TopCount)) n_r <= n_r + TopW'(1);
          end
          if (cnt_r == (PortW+1)'(PortCount - 1)) begin
            ei_r     <= '0;
            rest_p_r <= all_p_r - non_p_r;
            rest_b_r <= all_b_r - non_b_r;
            st_r     <= S_EMIT;
          end else begin
            cnt_r  <= cnt_r + (PortW+1)'(1);
            addr_r <= addr_r + PortW'(1);
            st_r   <= S_SCAN_RD;
          end
        end
        S_EMIT: if (!row_v_r || row_ready) begin
          if (ei_r == n_r) st_r <= S_ALL;
          else begin
            row_r.kind  <= ROW_TOP;
            row_r.port  <= t_port_r[ei_r[TopW-1:0] < TopW'(TopCount) ? ei_r : '0];
            row_r.pkts  <= t_pk_r[ei_r];
            row_r.bytes <= t_by_r[ei_r];
            row_r.last  <= 1'b0;
            rest_p_r    <= rest_p_r - t_pk_r[ei_r];
            rest_b_r    <= rest_b_r - t_by_r[ei_r];
            ei_r        <= ei_r + TopW'(1);
          end
        end
        S_ALL: if (!row_v_r || row_ready) begin
          row_r   <= '{ROW_ALL, 16'd0, all_p_r, all_b_r, 1'b0};
          st_r    <= S_NONIP;
        end
        S_NONIP: if (!row_v_r || row_ready) begin
          row_r   <= '{ROW_NONIP, 16'd0, non_p_r, non_b_r, 1'b0};
          st_r    <= S_REST;
        end
        S_REST: if (!row_v_r || row_ready) begin
          row_r   <= '{ROW_REST, 16'd0, rest_p_r, rest_b_r, 1'b1};
          st_r    <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
